// ----- hdl/dorq_pkg.sv -----
package dorq_pkg;

    // Request op codes
    localparam logic [1:0] OP_SORTED_INSERT = 2'd0;
    localparam logic [1:0] OP_FRONT_INSERT  = 2'd1;
    localparam logic [1:0] OP_EXTRACT       = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Depth of the command queue between front and back
    localparam int CMD_FIFO_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  task_handle;
        logic [31:0] deadline;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  head_handle;
        logic [31:0] head_deadline;
        logic        queue_empty;
        logic [4:0]  occupancy;
    } rsp_t;

    // Command class decided by the front end
    typedef enum logic [1:0] {
        CLS_SORTED,
        CLS_FRONT,
        CLS_EXTRACT,
        CLS_NOP
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [7:0]  task_handle;
        logic [31:0] deadline;
    } cmd_t;

    // Front-to-back command queue head
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_q_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_APPLY
    } bk_state_t;

endpackage

// ----- hdl/dorq_front.sv -----
module dorq_front
    import dorq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_ready,
    input  req_t   req,
    output cmd_q_t cmd_q,
    input  logic   cmd_pop
);

    localparam int PW = $clog2(CMD_FIFO_DEPTH);
    localparam int FW = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t          fifo_reg [CMD_FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    cmd_t          cmd_new;
    logic          push;

    // Classify the op code
    always_comb
    begin
        cmd_new.task_handle = req.task_handle;
        cmd_new.deadline    = req.deadline;
        case (req.op)
            OP_SORTED_INSERT: cmd_new.cls = CLS_SORTED;
            OP_FRONT_INSERT:  cmd_new.cls = CLS_FRONT;
            OP_EXTRACT:       cmd_new.cls = CLS_EXTRACT;
            default:          cmd_new.cls = CLS_NOP;
        endcase
    end

    assign req_ready = (fill_reg != FW'(CMD_FIFO_DEPTH));
    assign push      = req_valid && req_ready;

    assign cmd_q.valid = (fill_reg != '0);
    assign cmd_q.cmd   = fifo_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (cmd_pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule

// ----- hdl/dorq_back.sv -----
module dorq_back
    import dorq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int DEADLINE_BITS = 32
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  cmd_q_t cmd_q,
    output logic   cmd_pop,
    output logic   rsp_valid,
    input  logic   rsp_ready,
    output rsp_t   rsp
);

    localparam int N  = QUEUE_DEPTH;
    localparam int DW = DEADLINE_BITS;
    localparam int CW = $clog2(N + 1);
    localparam int LV = $clog2(N);

    logic [7:0]    hdl_reg  [N];
    logic [7:0]    hdl_next [N];
    logic [DW-1:0] dl_reg   [N];
    logic [DW-1:0] dl_next  [N];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    bk_state_t     state_reg;
    bk_state_t     state_next;
    cmd_t          cmd_reg;
    logic [N-1:0]  flag_reg;
    logic [N-1:0]  flag_next;
    logic          out_valid_reg;
    rsp_t          out_reg;
    rsp_t          out_next;

    logic [N-1:0]  pre [LV+1];
    logic [N-1:0]  incl;
    logic [N-1:0]  excl;
    logic [N-1:0]  first;
    logic          any_hit;
    logic          full;
    logic          commit;
    logic [1:0]    status;
    logic [DW-1:0] cmd_dl;
    logic [DW+31:0] dl_in_w;
    logic [DW+31:0] head_dl_w;
    logic [CW+4:0]  occ_w;

    // Deadline taken in its low DEADLINE_BITS bits
    assign dl_in_w = {{DW{1'b0}}, cmd_reg.deadline};
    assign cmd_dl  = dl_in_w[DW-1:0];

    // Per-slot compare, registered in the scan cycle
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            logic used;
            used = (CW'(i) < count_reg);
            case (cmd_reg.cls)
                CLS_SORTED:  flag_next[i] = used && (dl_reg[i] >= cmd_dl);
                CLS_EXTRACT: flag_next[i] = used && (hdl_reg[i] == cmd_reg.task_handle);
                default:     flag_next[i] = 1'b0;
            endcase
        end
    end

    // Log-depth prefix OR over the hit flags
    always_comb
    begin
        pre[0] = flag_reg;
        for (int l = 0; l < LV; l++)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (i >= (1 << l))
                begin
                    pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
                end
                else
                begin
                    pre[l+1][i] = pre[l][i];
                end
            end
        end
        incl = pre[LV];
        excl = {incl[N-2:0], 1'b0};
    end

    assign first   = flag_reg & ~excl;
    assign any_hit = incl[N-1];
    assign full    = (count_reg == CW'(N));

    // Shift network: insert opens a slot, extract closes one
    always_comb
    begin
        count_next = count_reg;
        status     = ST_OK;
        for (int i = 0; i < N; i++)
        begin
            hdl_next[i] = hdl_reg[i];
            dl_next[i]  = dl_reg[i];
        end
        case (cmd_reg.cls)
            CLS_SORTED, CLS_FRONT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    for (int i = 0; i < N; i++)
                    begin
                        logic ins;
                        logic shift;
                        if (cmd_reg.cls == CLS_FRONT)
                        begin
                            ins   = (i == 0);
                            shift = (i > 0);
                        end
                        else
                        begin
                            ins   = first[i] || (!any_hit && (CW'(i) == count_reg));
                            shift = excl[i];
                        end
                        if (ins)
                        begin
                            hdl_next[i] = cmd_reg.task_handle;
                            dl_next[i]  = cmd_dl;
                        end
                        else if (shift && (i > 0))
                        begin
                            hdl_next[i] = hdl_reg[i-1];
                            dl_next[i]  = dl_reg[i-1];
                        end
                    end
                end
            end
            CLS_EXTRACT:
            begin
                if (any_hit)
                begin
                    count_next = count_reg - 1'b1;
                    for (int i = 0; i < N - 1; i++)
                    begin
                        if (incl[i])
                        begin
                            hdl_next[i] = hdl_reg[i+1];
                            dl_next[i]  = dl_reg[i+1];
                        end
                    end
                end
                else
                begin
                    status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // Result built from the post-step head and count
    always_comb
    begin
        head_dl_w = {32'b0, dl_next[0]};
        occ_w     = {5'b0, count_next};
        out_next.status    = status;
        out_next.occupancy = occ_w[4:0];
        if (count_next == '0)
        begin
            out_next.head_handle   = '0;
            out_next.head_deadline = '0;
            out_next.queue_empty   = 1'b1;
        end
        else
        begin
            out_next.head_handle   = hdl_next[0];
            out_next.head_deadline = head_dl_w[31:0];
            out_next.queue_empty   = 1'b0;
        end
    end

    assign commit = (state_reg == BK_APPLY) && (!out_valid_reg || rsp_ready);

    // Sequencer: load, scan, apply
    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_q.valid)
                begin
                    cmd_pop    = 1'b1;
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                state_next = BK_APPLY;
            end
            BK_APPLY:
            begin
                if (commit)
                begin
                    if (cmd_q.valid)
                    begin
                        cmd_pop    = 1'b1;
                        state_next = BK_SCAN;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_q.cmd;
        end
        if (state_reg == BK_SCAN)
        begin
            flag_reg <= flag_next;
        end
        if (commit)
        begin
            out_reg <= out_next;
            for (int i = 0; i < N; i++)
            begin
                hdl_reg[i] <= hdl_next[i];
                dl_reg[i]  <= dl_next[i];
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ----- hdl/deadline_ordered_ready_queue_core.sv -----
// Path: with the back end free, a request is loaded from the command queue, its slots
// are compared in parallel, and the shift and result register then apply it.
// Overlap: the back end takes no new request until the compare and apply steps of the
// last are done; the two-entry command queue and result register decouple both sides.
// Reset: asynchronous active-low rst_n empties the queue and both channels.
module deadline_ordered_ready_queue_core
    import dorq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int DEADLINE_BITS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_q_t cmd_q;
    logic   cmd_pop;

    // Front end: accept and classify
    dorq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_q     (cmd_q),
        .cmd_pop   (cmd_pop)
    );

    // Back end: sorted slot array and result register
    dorq_back #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .DEADLINE_BITS (DEADLINE_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_q     (cmd_q),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ----- tb/sv/edf_queue_checker.sv -----
// Watches both channels of the deadline-ordered ready queue, keeps a shadow copy
// of the queue, and compares every result transfer with the oldest prediction.
module edf_queue_checker
    import dorq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   failures,
    output int   outstanding,
    output int   results_checked,
    output int   full_rejects,
    output int   missed_extracts
);

    // Shadow queue, slot 0 is the head
    logic [7:0]  shadow_handle   [QUEUE_DEPTH];
    logic [31:0] shadow_deadline [QUEUE_DEPTH];
    int          shadow_count;

    // Predicted results, oldest first
    rsp_t pending_heads [$];

    initial begin
        failures        = 0;
        outstanding     = 0;
        results_checked = 0;
        full_rejects    = 0;
        missed_extracts = 0;
        shadow_count    = 0;
    end

    // Apply one request to the shadow queue and return the result it should produce
    function automatic rsp_t apply_to_shadow_queue(input req_t r);
        rsp_t res;
        int   pos;
        bit   hit;
        res        = '0;
        res.status = ST_OK;
        pos        = 0;
        hit        = 1'b0;
        case (r.op)
            OP_SORTED_INSERT, OP_FRONT_INSERT:
            begin
                if (shadow_count >= QUEUE_DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    // ties go ahead of held entries with the same deadline
                    if (r.op == OP_SORTED_INSERT)
                    begin
                        while (pos < shadow_count && shadow_deadline[pos] < r.deadline)
                            pos++;
                    end
                    for (int i = shadow_count; i > pos; i--)
                    begin
                        shadow_handle[i]   = shadow_handle[i - 1];
                        shadow_deadline[i] = shadow_deadline[i - 1];
                    end
                    shadow_handle[pos]   = r.task_handle;
                    shadow_deadline[pos] = r.deadline;
                    shadow_count++;
                end
            end
            OP_EXTRACT:
            begin
                // first match from the head wins
                while (pos < shadow_count && !hit)
                begin
                    if (shadow_handle[pos] == r.task_handle)
                        hit = 1'b1;
                    else
                        pos++;
                end
                if (hit)
                begin
                    for (int i = pos; i + 1 < shadow_count; i++)
                    begin
                        shadow_handle[i]   = shadow_handle[i + 1];
                        shadow_deadline[i] = shadow_deadline[i + 1];
                    end
                    shadow_count--;
                end
                else
                begin
                    res.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                // unused op code: no change, status ok
            end
        endcase
        if (shadow_count > 0)
        begin
            res.head_handle   = shadow_handle[0];
            res.head_deadline = shadow_deadline[0];
            res.queue_empty   = 1'b0;
        end
        else
        begin
            res.head_handle   = '0;
            res.head_deadline = '0;
            res.queue_empty   = 1'b1;
        end
        res.occupancy = 5'(shadow_count);
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    // Result transfers are matched before request transfers of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            shadow_count = 0;
            pending_heads.delete();
            outstanding  = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending_heads.size() == 0)
                begin
                    $error("result transfer with no request waiting: status %0d occupancy %0d",
                           rsp.status, rsp.occupancy);
                    failures++;
                end
                else
                begin
                    want = pending_heads.pop_front();
                    compare_field("status", 32'(want.status), 32'(rsp.status));
                    compare_field("head_handle", 32'(want.head_handle), 32'(rsp.head_handle));
                    compare_field("head_deadline", want.head_deadline, rsp.head_deadline);
                    compare_field("queue_empty", 32'(want.queue_empty), 32'(rsp.queue_empty));
                    compare_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
                    results_checked++;
                    if (want.status == ST_FULL)
                        full_rejects++;
                    if (want.status == ST_NOT_FOUND)
                        missed_extracts++;
                end
            end
            if (req_valid && req_ready)
                pending_heads.push_back(apply_to_shadow_queue(req));
            outstanding = pending_heads.size();
        end
    end

endmodule

// ----- tb/sv/deadline_ordered_ready_queue_core_test.sv -----
// Stimulus and verdict for the deadline-ordered ready queue core.
module deadline_ordered_ready_queue_core_test;
    import dorq_pkg::*;

    localparam int          QUEUE_DEPTH  = 16;
    localparam int          ITEM_COUNT   = 1900;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          STALL_CYCLES = 80;
    localparam int          STALL_BURST  = 24;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    int failures;
    int outstanding;
    int results_checked;
    int full_rejects;
    int missed_extracts;

    int send_idle_pct;
    int recv_idle_pct;
    int stall_request;
    int requests_sent;
    int cycle_count;

    deadline_ordered_ready_queue_core #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .DEADLINE_BITS (32)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    edf_queue_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp             (rsp),
        .failures        (failures),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .full_rejects    (full_rejects),
        .missed_extracts (missed_extracts)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, outstanding);
        $display("deadline_ordered_ready_queue_core verification failed");
        $finish;
    end

    // Result side: random back-pressure plus requested long hold-offs
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request > 0)
            begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one request, with random idle cycles ahead of it, and wait for its transfer
    task automatic offer_request(input logic [1:0] op, input logic [7:0] handle,
                                 input logic [31:0] deadline);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid       <= 1'b1;
        req.op          <= op;
        req.task_handle <= handle;
        req.deadline    <= deadline;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        requests_sent++;
    endtask

    // Random request; small handle pool so extracts mostly hit, small deadlines for ties
    function automatic req_t random_request(input int insert_pct);
        req_t r;
        int   roll;
        roll = $urandom_range(99);
        if (roll < 3)
            r.op = OP_UNUSED;
        else if (roll < insert_pct)
            r.op = ($urandom_range(3) == 0) ? OP_FRONT_INSERT : OP_SORTED_INSERT;
        else
            r.op = OP_EXTRACT;
        if ($urandom_range(9) == 0)
            r.task_handle = 8'($urandom);
        else
            r.task_handle = 8'($urandom_range(23));
        case ($urandom_range(5))
            0, 1:    r.deadline = $urandom;
            2:       r.deadline = 32'($urandom_range(7));
            3:       r.deadline = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: r.deadline = 32'($urandom_range(1000));
        endcase
        return r;
    endfunction

    // Main stimulus
    initial
    begin
        req_t r;
        int   insert_pct;
        rst_n         <= 1'b0;
        req_valid     <= 1'b0;
        req           <= '0;
        send_idle_pct = 12;
        recv_idle_pct = 85;
        stall_request = 0;
        requests_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty queue, ties, front insert, duplicates, miss, unused op, full
        offer_request(OP_EXTRACT,       8'd9,   32'h0);
        offer_request(OP_UNUSED,        8'd0,   32'h0);
        offer_request(OP_SORTED_INSERT, 8'd0,   32'h0);
        offer_request(OP_SORTED_INSERT, 8'hFF,  32'hFFFF_FFFF);
        offer_request(OP_SORTED_INSERT, 8'd1,   32'h0);
        offer_request(OP_FRONT_INSERT,  8'd2,   32'hFFFF_FFFF);
        offer_request(OP_SORTED_INSERT, 8'd0,   32'd5);
        offer_request(OP_EXTRACT,       8'd0,   32'hFFFF_FFFF);
        offer_request(OP_EXTRACT,       8'd77,  32'h0);
        offer_request(OP_UNUSED,        8'hFF,  32'hFFFF_FFFF);
        for (int k = 0; k < QUEUE_DEPTH - 4; k++)
            offer_request(OP_SORTED_INSERT, 8'(100 + k), $urandom);
        offer_request(OP_SORTED_INSERT, 8'd50,  32'h0);
        offer_request(OP_FRONT_INSERT,  8'd51,  32'h0);

        // Random: insert-heavy and extract-heavy stretches alternate
        for (int n = 0; n < ITEM_COUNT; n++)
        begin
            if (n == ITEM_COUNT / 3)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 12;
            end
            if (n == 2 * ITEM_COUNT / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // hold the result side off while requests keep coming
                stall_request = STALL_CYCLES;
                for (int k = 0; k < STALL_BURST; k++)
                begin
                    r = random_request(70);
                    offer_request(r.op, r.task_handle, r.deadline);
                end
                // pause until every result is back
                req_valid <= 1'b0;
                while (outstanding != 0)
                    @(posedge clk);
            end
            insert_pct = ((n / 50) % 2 == 0) ? 70 : 30;
            r = random_request(insert_pct);
            offer_request(r.op, r.task_handle, r.deadline);
        end
        req_valid <= 1'b0;

        // Drain
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests and %0d checked results", requests_sent,
                 results_checked);
        $display("  including %0d full-queue rejects and %0d extracts of absent handles",
                 full_rejects, missed_extracts);
        if (failures == 0)
            $display("deadline_ordered_ready_queue_core verification clean");
        else
            $display("deadline_ordered_ready_queue_core verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/dorq_pkg.sv
hdl/dorq_front.sv
hdl/dorq_back.sv
hdl/deadline_ordered_ready_queue_core.sv
tb/sv/edf_queue_checker.sv
tb/sv/deadline_ordered_ready_queue_core_test.sv
